// ===== rtl/tli_pkg.sv =====
// Shared types, constants and the microcode table of the table interpolator.
// Used by every module in the rtl folder but tli_ram; depends on nothing else.
package tli_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned EIDX_W      = 8;
  localparam int unsigned PROD_W      = 2 * VAL_W;
  localparam int unsigned DIV_STEPS   = VAL_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REGION_BELOW    = 2'd0,
    REGION_ABOVE    = 2'd1,
    REGION_INTERIOR = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    ADDR_ZERO = 2'd0,
    ADDR_LAST = 2'd1,
    ADDR_MID  = 2'd2
  } addr_sel_e;

  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_QUERY  = 3'd2,
    COND_CLAMP     = 3'd3,
    COND_SPAN_DONE = 3'd4,
    COND_DIV_BUSY  = 3'd5,
    COND_OUT_FREE  = 3'd6
  } cond_e;

  typedef enum logic [3:0] {
    STEP_IDLE     = 4'd0,
    STEP_INIT     = 4'd1,
    STEP_LOAD_LO  = 4'd2,
    STEP_LOAD_HI  = 4'd3,
    STEP_CLAMP    = 4'd4,
    STEP_PROBE    = 4'd5,
    STEP_NARROW   = 4'd6,
    STEP_DIFF     = 4'd7,
    STEP_MUL      = 4'd8,
    STEP_DIV_GO   = 4'd9,
    STEP_DIV_WAIT = 4'd10,
    STEP_BLEND    = 4'd11,
    STEP_OUT      = 4'd12,
    STEP_RETRY    = 4'd13
  } step_e;

  typedef struct packed {
    logic      idle;
    addr_sel_e addr_sel;
    logic      init;
    logic      ld_lo;
    logic      ld_hi;
    logic      clamp;
    logic      narrow;
    logic      diff;
    logic      mul;
    logic      div_start;
    logic      blend;
    logic      out_wr;
    cond_e     cond;
    step_e     target;
  } ctrl_t;

  typedef struct packed {
    logic query_acc;
    logic clamp;
    logic span_done;
    logic div_busy;
    logic out_free;
  } flags_t;

  // The microprogram: one control word per step. A true condition jumps to
  // the target, otherwise the sequencer moves on to the following step.
  function automatic ctrl_t ucode(step_e step);
    ctrl_t c;
    c = '0;
    case (step)
      STEP_IDLE: begin
        c.idle   = 1'b1;
        c.cond   = COND_NO_QUERY;
        c.target = STEP_IDLE;
      end
      STEP_INIT: begin
        c.init     = 1'b1;
        c.addr_sel = ADDR_ZERO;
      end
      STEP_LOAD_LO: begin
        c.ld_lo    = 1'b1;
        c.addr_sel = ADDR_LAST;
      end
      STEP_LOAD_HI: begin
        c.ld_hi = 1'b1;
      end
      STEP_CLAMP: begin
        c.clamp  = 1'b1;
        c.cond   = COND_CLAMP;
        c.target = STEP_OUT;
      end
      STEP_PROBE: begin
        c.addr_sel = ADDR_MID;
        c.cond     = COND_SPAN_DONE;
        c.target   = STEP_DIFF;
      end
      STEP_NARROW: begin
        c.addr_sel = ADDR_MID;
        c.narrow   = 1'b1;
        c.cond     = COND_ALWAYS;
        c.target   = STEP_PROBE;
      end
      STEP_DIFF: begin
        c.diff = 1'b1;
      end
      STEP_MUL: begin
        c.mul = 1'b1;
      end
      STEP_DIV_GO: begin
        c.div_start = 1'b1;
      end
      STEP_DIV_WAIT: begin
        c.cond   = COND_DIV_BUSY;
        c.target = STEP_DIV_WAIT;
      end
      STEP_BLEND: begin
        c.blend = 1'b1;
      end
      STEP_OUT: begin
        c.out_wr = 1'b1;
        c.cond   = COND_OUT_FREE;
        c.target = STEP_IDLE;
      end
      STEP_RETRY: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_OUT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module tli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tli_div.sv =====
// Restoring divider, one quotient bit per cycle, for a dividend whose upper
// half is below the divisor. Depends on tli_pkg.
module tli_div
  import tli_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [VAL_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic [VAL_W-1:0]  quotient_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0]     rem_q, rem_d;
  logic [VAL_W-1:0]     quo_q, quo_d;
  logic [VAL_W:0]       trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[VAL_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      rem_d = dividend_i[PROD_W-1:VAL_W];
      quo_d = dividend_i[VAL_W-1:0];
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      rem_d = fits ? VAL_W'(trial - {1'b0, divisor_i}) : trial[VAL_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/tli_seq.sv =====
// Microcode sequencer: step counter, control word lookup and conditional
// jumps. Depends on tli_pkg for the control word table and its types.
module tli_seq
  import tli_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  step_e step_q, step_d;
  ctrl_t ctrl;
  logic  take;

  assign ctrl = ucode(step_q);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_QUERY:  take = !flags_i.query_acc;
      COND_CLAMP:     take = flags_i.clamp;
      COND_SPAN_DONE: take = flags_i.span_done;
      COND_DIV_BUSY:  take = flags_i.div_busy;
      COND_OUT_FREE:  take = flags_i.out_free;
      default:        take = 1'b1;
    endcase
    step_d = take ? ctrl.target : step_e'(step_q + 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ===== rtl/table_linear_interpolator.sv =====
// Top level of the table interpolator: ports, table memories, datapath and
// output register. Depends on tli_pkg, tli_ram, tli_div and tli_seq.
//
//   Channel   Signals                                       Direction
//   config    cfg_we_i, cfg_wdata_i                         in, no wait
//   input     in_valid_i, in_ready_o, operation_i,          in
//             entry_index_i, position_i, sample_i
//   output    out_valid_o, out_ready_i, interpolated_o,     out
//             region_o
//
// A load item is written into both memories at its acceptance edge.
// A clamped query runs init, both table loads and the clamp test, then output;
// an interior query adds k search steps, at most ceil(log2(n - 1)) for n
// entries in use, each a probe and a narrow over the registered memory port,
// then the difference, the product, the bit-serial divider and the blend.
// Reset sets table_size to 2 and idles the sequencer; the tables are not
// cleared. A waiting result holds the sequencer at its output and retry steps only.
module table_linear_interpolator
  import tli_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [EIDX_W-1:0] entry_index_i,
  input  logic [VAL_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  sample_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  interpolated_o,
  output logic [1:0]        region_o
);

  ctrl_t ctrl;
  flags_t flags;

  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  last_idx;
  logic [31:0]       size_ext;

  logic              in_acc;
  logic              ram_we;
  logic [IDX_W-1:0]  raddr;
  logic [VAL_W-1:0]  rd_bp, rd_s;

  logic [VAL_W-1:0]  pos_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic [VAL_W-1:0]  bp_lo_q, bp_hi_q, s_lo_q, s_hi_q;
  logic              clamp_lo, clamp_hi;

  logic              up_q;
  logic [VAL_W-1:0]  diff_q, d_q, w_q;
  logic [PROD_W-1:0] prod_q;
  logic              div_busy;
  logic [VAL_W-1:0]  quo;
  logic [VAL_W:0]    sum_up;

  logic [VAL_W-1:0]  res_q, res_d;
  region_e           reg_q, reg_d;

  logic              out_valid_q;
  logic [VAL_W-1:0]  out_val_q;
  region_e           out_reg_q;
  logic              out_free;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  assign size_ext = 32'(size_q);

  always_comb begin
    if (size_ext < 32'd2) begin
      last_idx = IDX_W'(1);
    end else if (size_ext > TABLE_DEPTH) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(size_ext - 32'd1);
    end
  end

  tli_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  assign in_ready_o = ctrl.idle;
  assign in_acc     = in_valid_i && ctrl.idle;
  assign ram_we     = in_acc && (op_e'(operation_i) == OP_LOAD)
                      && (32'(entry_index_i) < TABLE_DEPTH);

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];

  always_comb begin
    case (ctrl.addr_sel)
      ADDR_ZERO: raddr = '0;
      ADDR_LAST: raddr = last_idx;
      ADDR_MID:  raddr = mid;
      default:   raddr = '0;
    endcase
  end

  tli_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_bp_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IDX_W'(entry_index_i)),
    .wdata_i(position_i),
    .raddr_i(raddr),
    .rdata_o(rd_bp)
  );

  tli_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IDX_W'(entry_index_i)),
    .wdata_i(sample_i),
    .raddr_i(raddr),
    .rdata_o(rd_s)
  );

  assign clamp_lo = pos_q <= bp_lo_q;
  assign clamp_hi = pos_q >= bp_hi_q;

  // Search bounds and the neighbouring entries.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q <= position_i;
    end
    if (ctrl.init) begin
      lo_q <= '0;
      hi_q <= last_idx;
    end else if (ctrl.narrow) begin
      if (rd_bp > pos_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid;
      end
    end
    if (ctrl.ld_lo || (ctrl.narrow && !(rd_bp > pos_q))) begin
      bp_lo_q <= rd_bp;
      s_lo_q  <= rd_s;
    end
    if (ctrl.ld_hi || (ctrl.narrow && (rd_bp > pos_q))) begin
      bp_hi_q <= rd_bp;
      s_hi_q  <= rd_s;
    end
  end

  // Interpolation datapath.
  always_ff @(posedge clk_i) begin
    if (ctrl.diff) begin
      up_q   <= s_hi_q >= s_lo_q;
      diff_q <= (s_hi_q >= s_lo_q) ? s_hi_q - s_lo_q : s_lo_q - s_hi_q;
      d_q    <= pos_q - bp_lo_q;
      w_q    <= bp_hi_q - bp_lo_q;
    end
    if (ctrl.mul) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(d_q);
    end
  end

  tli_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl.div_start),
    .dividend_i(prod_q),
    .divisor_i (w_q),
    .busy_o    (div_busy),
    .quotient_o(quo)
  );

  assign sum_up = {1'b0, s_lo_q} + {1'b0, quo};

  always_comb begin
    res_d = res_q;
    reg_d = reg_q;
    if (ctrl.clamp) begin
      if (clamp_lo) begin
        res_d = s_lo_q;
        reg_d = REGION_BELOW;
      end else if (clamp_hi) begin
        res_d = s_hi_q;
        reg_d = REGION_ABOVE;
      end
    end else if (ctrl.blend) begin
      reg_d = REGION_INTERIOR;
      if (w_q == '0) begin
        res_d = s_lo_q;
      end else if (up_q) begin
        res_d = sum_up[VAL_W] ? '1 : sum_up[VAL_W-1:0];
      end else begin
        res_d = (quo > s_lo_q) ? '0 : s_lo_q - quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    reg_q <= reg_d;
  end

  // Output register.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_wr && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_wr && out_free) begin
      out_val_q <= res_q;
      out_reg_q <= reg_q;
    end
  end

  assign flags.query_acc = in_acc && (op_e'(operation_i) == OP_QUERY);
  assign flags.clamp     = clamp_lo || clamp_hi;
  assign flags.span_done = (hi_q - lo_q) <= IDX_W'(1);
  assign flags.div_busy  = div_busy;
  assign flags.out_free  = out_free;

  assign out_valid_o    = out_valid_q;
  assign interpolated_o = out_val_q;
  assign region_o       = out_reg_q;

endmodule
